>>> rtl/per_channel_clamped_running_median_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clamped running median block
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_CLAMPED_RUNNING_MEDIAN_ASSERT_SVH
`define PER_CHANNEL_CLAMPED_RUNNING_MEDIAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcrm_pkg.sv
// ----------------------------------------------------------------------------
// pcrm_pkg
// Types and constants shared by the clamped running median block.
// ----------------------------------------------------------------------------
package pcrm_pkg;

  localparam int FINGER_W = 3;
  localparam int IN_FORCE_W = 24;
  localparam int FORCE_W = 23;
  localparam int CHANNELS_DEFAULT = 5;
  localparam int WINDOW_DEFAULT = 8;

  typedef logic [FORCE_W-1:0] force_t;

  typedef struct packed {
    logic [FINGER_W-1:0]          finger;
    logic signed [IN_FORCE_W-1:0] simple_sum_force;
    logic signed [IN_FORCE_W-1:0] weighted_sum_force;
  } in_t;

  typedef struct packed {
    logic [FINGER_W-1:0] channel;
    force_t              clamped_force;
    force_t              median_force;
  } out_t;

  typedef struct packed {
    logic   touched;
    force_t old_force;
  } win_old_t;

  typedef struct packed {
    logic   valid;
    logic   touched;
    force_t old_force;
    force_t new_force;
  } sort_start_t;

  typedef struct packed {
    logic   done;
    force_t median;
  } sort_res_t;

endpackage

>>> rtl/per_channel_clamped_running_median.sv
// ----------------------------------------------------------------------------
// per_channel_clamped_running_median
// Accepts a new sample only in the idle state, once the previous result has
// been loaded into the output register; the rate is set by the walk over the
// sorted window memory, one entry per cycle through its single read port.
// Reset clears write pointers, wrap flags and the mode register; window entries
// read as zero until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module per_channel_clamped_running_median #(
  parameter int CHANNELS = pcrm_pkg::CHANNELS_DEFAULT,
  parameter int WINDOW   = pcrm_pkg::WINDOW_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pcrm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pcrm_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);
  import pcrm_pkg::*;

`include "per_channel_clamped_running_median_assert.svh"

  localparam int CW = $clog2(CHANNELS > 1 ? CHANNELS : 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OLD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic        use_weighted_q;
  logic        out_valid_q;
  out_t        out_q;
  logic [CW-1:0] ch_q;
  force_t      new_q;

  logic signed [IN_FORCE_W-1:0] sel;
  force_t      clamped;
  logic        in_range;
  logic        accept;
  logic        push;
  logic [CW-1:0] in_ch;
  logic        slot_free;
  logic        load;
  win_old_t    win_old;
  sort_start_t sort_start;
  sort_res_t   sort_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign sel         = use_weighted_q ? in_data_i.weighted_sum_force
                                      : in_data_i.simple_sum_force;
  assign clamped     = sel[IN_FORCE_W-1] ? '0 : sel[FORCE_W-1:0];
  assign in_range    = {2'b00, in_data_i.finger} < 5'(CHANNELS);
  assign in_ch       = CW'(in_data_i.finger);
  assign push        = accept && in_range;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (push) begin
          state_d = S_OLD;
        end
      end
      S_OLD: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (sort_res.done) begin
          if (slot_free) begin
            load    = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      use_weighted_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        use_weighted_q <= cfg_data_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ch_q  <= in_ch;
      new_q <= clamped;
    end
    if (load) begin
      out_q.channel       <= FINGER_W'(ch_q);
      out_q.clamped_force <= new_q;
      out_q.median_force  <= sort_res.median;
    end
  end

  assign sort_start.valid     = (state_q == S_OLD);
  assign sort_start.touched   = win_old.touched;
  assign sort_start.old_force = win_old.old_force;
  assign sort_start.new_force = new_q;

  pcrm_window #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ch_i   (in_ch),
    .force_i(clamped),
    .old_o  (win_old)
  );

  pcrm_sort #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_sort (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sort_start),
    .ch_i   (ch_q),
    .res_o  (sort_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PCRM_ASSERT_SAME(a_done_in_walk, sort_res.done, state_q == S_WALK, "sort done outside walk")
  `PCRM_ASSERT_NEXT(a_push_starts, push, state_q == S_OLD, "push did not start a read")
  `PCRM_ASSERT_SAME(a_out_rise, $rose(out_valid_q),
                    $past(state_q) == S_WALK || $past(state_q) == S_OUT,
                    "result appeared without a finished walk")

endmodule

>>> rtl/pcrm_window.sv
// ----------------------------------------------------------------------------
// pcrm_window
// Ring buffer memory of raw samples with per-channel write pointers. A push
// writes the new sample and returns the sample it replaces in the next cycle.
// ----------------------------------------------------------------------------
module pcrm_window #(
  parameter int CHANNELS = pcrm_pkg::CHANNELS_DEFAULT,
  parameter int WINDOW   = pcrm_pkg::WINDOW_DEFAULT
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  logic [$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0] ch_i,
  input  pcrm_pkg::force_t                            force_i,
  output pcrm_pkg::win_old_t                          old_o
);
  import pcrm_pkg::*;

  localparam int CW = $clog2(CHANNELS > 1 ? CHANNELS : 2);
  localparam int IW = $clog2(WINDOW > 1 ? WINDOW : 2);
  localparam int DEPTH = CHANNELS << IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);

  logic [IW-1:0] wp_q [CHANNELS];
  logic          wrap_q [CHANNELS];
  force_t        mem_q [DEPTH];
  force_t        rdata_q;
  logic          old_valid_q;
  logic          touched_q;
  logic [IW-1:0] wp;
  logic [CW+IW-1:0] addr;

  assign wp   = wp_q[ch_i];
  assign addr = {ch_i, wp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]   <= '0;
        wrap_q[c] <= 1'b0;
      end
    end else if (push_i) begin
      if (wp == LAST_IDX) begin
        wp_q[ch_i]   <= '0;
        wrap_q[ch_i] <= 1'b1;
      end else begin
        wp_q[ch_i] <= wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rdata_q     <= mem_q[addr];
      mem_q[addr] <= force_i;
      old_valid_q <= wrap_q[ch_i];
      touched_q   <= wrap_q[ch_i] | (wp != '0);
    end
  end

  assign old_o.touched   = touched_q;
  assign old_o.old_force = old_valid_q ? rdata_q : '0;

endmodule

>>> rtl/pcrm_sort.sv
// ----------------------------------------------------------------------------
// pcrm_sort
// Sorted copy of each channel window in memory. One walk reads the sorted
// entries in order, drops the replaced sample, merges in the new one, writes
// the list back and captures the two middle entries for the median.
// ----------------------------------------------------------------------------
module pcrm_sort #(
  parameter int CHANNELS = pcrm_pkg::CHANNELS_DEFAULT,
  parameter int WINDOW   = pcrm_pkg::WINDOW_DEFAULT
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  pcrm_pkg::sort_start_t                       start_i,
  input  logic [$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0] ch_i,
  output pcrm_pkg::sort_res_t                         res_o
);
  import pcrm_pkg::*;

  localparam int CW = $clog2(CHANNELS > 1 ? CHANNELS : 2);
  localparam int IW = $clog2(WINDOW > 1 ? WINDOW : 2);
  localparam int DEPTH = CHANNELS << IW;
  localparam logic [IW:0]   WIN_CNT = (IW + 1)'(WINDOW);
  localparam logic [IW:0]   LAST_RD = (IW + 1)'(WINDOW - 1);
  localparam logic [IW-1:0] MID_LO = IW'((WINDOW - 1) / 2);
  localparam logic [IW-1:0] MID_HI = IW'(WINDOW / 2);

  force_t           mem_q [DEPTH];
  force_t           rdata_q;
  logic             busy_q, dval_q, dlast_q, fin_q, done_q;
  logic [CW-1:0]    ch_q;
  logic             touched_q, removed_q;
  force_t           old_q, carry_q, lo_q, hi_q;
  logic [IW:0]      rd_idx_q;
  logic [IW-1:0]    wr_idx_q;

  logic             rd_go;
  logic [IW:0]      rd_cur;
  logic [CW+IW-1:0] rd_addr;
  force_t           elem;
  logic             skip;
  logic             wr_en;
  force_t           wr_data;
  logic [FORCE_W:0] mid_sum;

  always_comb begin
    rd_go   = 1'b0;
    rd_cur  = rd_idx_q;
    rd_addr = {ch_q, rd_idx_q[IW-1:0]};
    if (start_i.valid) begin
      rd_go   = 1'b1;
      rd_cur  = '0;
      rd_addr = {ch_i, {IW{1'b0}}};
    end else if (busy_q && (rd_idx_q < WIN_CNT)) begin
      rd_go = 1'b1;
    end
  end

  assign elem    = touched_q ? rdata_q : '0;
  assign skip    = !removed_q && (elem == old_q);
  assign wr_en   = (dval_q && !skip) || fin_q;
  assign wr_data = fin_q ? carry_q : ((carry_q <= elem) ? carry_q : elem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      dval_q  <= 1'b0;
      dlast_q <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      dval_q  <= rd_go;
      dlast_q <= rd_go && (rd_cur == LAST_RD);
      fin_q   <= dval_q && dlast_q;
      done_q  <= fin_q;
      if (start_i.valid) begin
        busy_q <= 1'b1;
      end else if (fin_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.valid) begin
      ch_q      <= ch_i;
      touched_q <= start_i.touched;
      old_q     <= start_i.old_force;
      carry_q   <= start_i.new_force;
      removed_q <= 1'b0;
      rd_idx_q  <= (IW + 1)'(1);
      wr_idx_q  <= '0;
    end else begin
      if (rd_go) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (dval_q) begin
        if (skip) begin
          removed_q <= 1'b1;
        end else begin
          carry_q  <= (carry_q <= elem) ? elem : carry_q;
          wr_idx_q <= wr_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
    if (wr_en) begin
      mem_q[{ch_q, wr_idx_q}] <= wr_data;
      if (wr_idx_q == MID_LO) begin
        lo_q <= wr_data;
      end
      if (wr_idx_q == MID_HI) begin
        hi_q <= wr_data;
      end
    end
  end

  assign mid_sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign res_o.done   = done_q;
  assign res_o.median = mid_sum[FORCE_W:1];

endmodule

>>> tb/sv/tb_per_channel_clamped_running_median.sv
// ----------------------------------------------------------------------------
// tb_per_channel_clamped_running_median
// Self-checking testbench for the per-finger clamped running median filter.
// A behavioral model keeps its own copy of every finger window, write pointer
// and mode bit. It predicts clamped force and window median for each accepted
// in-range sample, and a checker compares every result transaction in order.
// Directed extremes and mode checks run first. Random traffic under changing
// handshake idling follows, and the run ends with a long receiver stall.
// ----------------------------------------------------------------------------
module tb_per_channel_clamped_running_median;
  timeunit 1ns;
  timeprecision 1ps;

  import pcrm_pkg::*;

  localparam int  CH           = 5;
  localparam int  WIN          = 8;
  localparam real CLK_PERIOD   = 12.0;
  localparam int  DRAIN_CYCLES = 4 * (WIN + 4);
  localparam int  LIMIT_CYCLES = 600000;
  localparam bit  MODE_SIMPLE   = 1'b0;
  localparam bit  MODE_WEIGHTED = 1'b1;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;

  force_t force_hist [CH][WIN];
  int     wr_ptr [CH];
  bit     use_weighted;
  out_t   expected_results [$];
  int     fail_count    = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_req      = 0;
  int     hold_left     = 0;

  per_channel_clamped_running_median #(
    .CHANNELS(CH),
    .WINDOW  (WIN)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  task automatic predict_filter(input in_t item, output bit has_res, output out_t res);
    logic signed [IN_FORCE_W-1:0] sel;
    force_t                       clamped;
    force_t                       sorted [WIN];
    force_t                       key;
    logic [FORCE_W:0]             mid_sum;
    int                           ch;
    int                           i;
    int                           j;
    has_res = 1'b0;
    res     = '0;
    if (item.finger >= CH) return;
    ch      = int'(item.finger);
    sel     = use_weighted ? item.weighted_sum_force : item.simple_sum_force;
    clamped = sel[IN_FORCE_W-1] ? '0 : sel[FORCE_W-1:0];
    force_hist[ch][wr_ptr[ch]] = clamped;
    wr_ptr[ch] = (wr_ptr[ch] == WIN - 1) ? 0 : wr_ptr[ch] + 1;
    for (i = 0; i < WIN; i++) sorted[i] = force_hist[ch][i];
    for (i = 1; i < WIN; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    res.channel       = item.finger;
    res.clamped_force = clamped;
    if (WIN % 2 == 1) begin
      res.median_force = sorted[WIN/2];
    end else begin
      mid_sum          = {1'b0, sorted[WIN/2-1]} + {1'b0, sorted[WIN/2]};
      res.median_force = mid_sum[FORCE_W:1];
    end
    has_res = 1'b1;
  endtask

  task automatic send_sample(input logic [FINGER_W-1:0] finger,
                             input logic signed [IN_FORCE_W-1:0] simple_f,
                             input logic signed [IN_FORCE_W-1:0] weighted_f);
    in_t  item;
    out_t res;
    bit   has_res;
    item.finger             = finger;
    item.simple_sum_force   = simple_f;
    item.weighted_sum_force = weighted_f;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    predict_filter(item, has_res, res);
    if (has_res) expected_results.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    use_weighted  = mode;
  endtask

  function automatic logic signed [IN_FORCE_W-1:0] random_force();
    case ($urandom_range(7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return '0;
      3:       return -24'($urandom_range(1, 2000));
      4, 5:    return 24'($urandom_range(0, 4000));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(MODE_SIMPLE);
    send_sample(3'd0, 24'sh7FFFFF, 24'sh800000);
    send_sample(3'd0, -24'sd1, 24'sh7FFFFF);
    send_sample(3'd1, 24'sh800000, 24'sh7FFFFF);
    send_sample(3'd5, 24'sh7FFFFF, 24'sh7FFFFF);
    send_sample(3'd6, 24'sh123456, 24'sh654321);
    send_sample(3'd7, 24'shFFFFFF, 24'sh000000);
    send_sample(3'd4, 24'sd1, -24'sd1);
    for (int k = 0; k <= WIN; k++) begin
      send_sample(3'd2, 24'sh7FFFFF - 24'(k), 24'sh800000);
    end
  endtask

  task automatic test_mode_select();
    write_mode(MODE_WEIGHTED);
    send_sample(3'd3, 24'sh800000, 24'sh7FFFFF);
    send_sample(3'd3, 24'sh7FFFFF, -24'sd1);
    send_sample(3'd3, 24'sh7FFFFF, 24'sh800000);
    send_sample(3'd3, 24'sh000000, 24'sd1);
    write_mode(MODE_SIMPLE);
    send_sample(3'd3, 24'sd5, 24'sh7FFFFF);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int num_items);
    int                  sent;
    int                  chunk;
    logic [FINGER_W-1:0] finger;
    sent = 0;
    while (sent < num_items) begin
      write_mode(1'($urandom_range(1)));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      chunk = 0;
      while (chunk < 110 && sent < num_items) begin
        if ($urandom_range(99) < 10) begin
          finger = FINGER_W'($urandom_range(CH, 7));
        end else begin
          finger = FINGER_W'($urandom_range(0, CH - 1));
          chunk++;
          sent++;
        end
        send_sample(finger, random_force(), random_force());
      end
    end
  endtask

  task automatic test_backpressure();
    write_mode(MODE_WEIGHTED);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 400;
    repeat (60) begin
      send_sample(FINGER_W'($urandom_range(0, CH - 1)), random_force(), random_force());
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: channel %0d", out_data.channel);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.channel !== exp_res.channel) begin
          $error("channel: expected %0d, actual %0d", exp_res.channel, out_data.channel);
          fail_count++;
        end
        if (out_data.clamped_force !== exp_res.clamped_force) begin
          $error("clamped_force: expected %0h, actual %0h",
                 exp_res.clamped_force, out_data.clamped_force);
          fail_count++;
        end
        if (out_data.median_force !== exp_res.median_force) begin
          $error("median_force: expected %0h, actual %0h",
                 exp_res.median_force, out_data.median_force);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int c = 0; c < CH; c++) begin
      wr_ptr[c] = 0;
      for (int w = 0; w < WIN; w++) force_hist[c][w] = '0;
    end
    use_weighted = MODE_SIMPLE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_mode_select();
    test_random_traffic(20, 60, 500);
    test_random_traffic(60, 20, 500);
    test_random_traffic(0, 0, 500);
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_per_channel_clamped_running_median passed");
    end else begin
      $display("tb_per_channel_clamped_running_median failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_per_channel_clamped_running_median failed");
    $finish;
  end

endmodule
